// ===== rtl/bcfd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the battery-management
// CAN frame decoder. No dependencies; used by bcfd_alu and the top level.
package bcfd_pkg;

  // Number of temperature points reported per module-temperature frame.
  localparam int TempPoints = 8;
  localparam int TempCount  = (TempPoints > 8) ? 8 : TempPoints;

  // Frame identifiers.
  localparam logic [28:0] IdCellFirst = 29'h180050F3;
  localparam logic [28:0] IdTempFirst = 29'h184050F3;
  localparam logic [28:0] IdTempLast  = 29'h184550F3;
  localparam logic [28:0] IdPackA     = 29'h186050F4;
  localparam logic [28:0] IdPackB     = 29'h186150F4;
  localparam logic [28:0] IdPackC     = 29'h186250F4;
  localparam logic [28:0] IdPackD     = 29'h186350F4;
  // Low half of the first cell identifier, used to find the module step.
  localparam logic [15:0] IdCellLow   = 16'h50F3;

  localparam logic [1:0]  ChanDecoded = 2'd2;
  localparam logic [15:0] CellsPerMod = 16'd6;
  localparam logic [15:0] WorkStateOfs = 16'd2;
  localparam logic [7:0]  WorkStateChg = 8'd3;
  localparam logic [7:0]  WorkStateChgOn = 8'd4;

  // Configuration register indexes and reset values.
  localparam logic [0:0] CfgTempOffset   = 1'b0;
  localparam logic [0:0] CfgCurrentScale = 1'b1;
  localparam logic [7:0] TempOffsetRst   = 8'd40;
  localparam logic [7:0] CurrentScaleRst = 8'd1;

  // Target codes of the write records.
  localparam logic [4:0] TgtCellVolt   = 5'd0;
  localparam logic [4:0] TgtModTemp    = 5'd1;
  localparam logic [4:0] TgtTotalVolt  = 5'd2;
  localparam logic [4:0] TgtTotalCurr  = 5'd3;
  localparam logic [4:0] TgtSoc        = 5'd4;
  localparam logic [4:0] TgtImdState   = 5'd5;
  localparam logic [4:0] TgtWorkState  = 5'd6;
  localparam logic [4:0] TgtMaxCell    = 5'd7;
  localparam logic [4:0] TgtMinCell    = 5'd8;
  localparam logic [4:0] TgtMaxTemp    = 5'd9;
  localparam logic [4:0] TgtMinTemp    = 5'd10;
  localparam logic [4:0] TgtAir1       = 5'd11;
  localparam logic [4:0] TgtAir2       = 5'd12;
  localparam logic [4:0] TgtAir3       = 5'd13;
  localparam logic [4:0] TgtChgEnable  = 5'd14;
  localparam logic [4:0] TgtChgReqVolt = 5'd15;
  localparam logic [4:0] TgtChgReqCurr = 5'd16;
  localparam logic [4:0] TgtChgOutVolt = 5'd17;

  typedef enum logic [2:0] {
    KindNone,
    KindCell,
    KindTemp,
    KindPackA,
    KindPackB,
    KindPackC,
    KindPackD
  } kind_e;

  // Request to and response from the shared adder/subtractor.
  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic        sub;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] sum;
    logic        carry;  // For a subtract: set when a >= b.
  } alu_rsp_t;

  // Index of the final record of a frame of the given kind.
  function automatic logic [2:0] last_index(kind_e kind);
    logic [2:0] idx;
    idx = 3'd0;
    case (kind)
      KindCell:  idx = 3'd3;
      KindTemp:  idx = 3'(TempCount - 1);
      KindPackA: idx = 3'd4;
      KindPackB: idx = 3'd1;
      KindPackC: idx = 3'd1;
      KindPackD: idx = 3'd6;
      default:   idx = 3'd0;
    endcase
    return idx;
  endfunction

  function automatic logic [15:0] sext8(logic [7:0] v);
    return {{8{v[7]}}, v};
  endfunction

endpackage

// ===== rtl/bms_can_frame_decoder_unit.sv =====
`timescale 1ns / 1ps
// Top level of the battery-management CAN frame decoder.
// Depends on bcfd_pkg and instantiates the shared adder bcfd_alu.
//
// The slave stream takes one received CAN frame per word: tuser carries the
// channel and the extended-identifier flag, tdata the identifier and the
// eight payload bytes. Frames that are not extended frames on channel 2, or
// whose identifier is unknown, are taken and give no words.
// Every other frame gives a run of register-write words on the master
// stream, one per field, with tlast on the final word of the run.
// All arithmetic runs through one 16-bit adder under a small sequencer:
// cell frames first divide the identifier step by six through repeated
// subtraction, and the charger frame scales the requested current by
// shift-and-add. After that one word is produced per cycle while the
// receiver is ready.
// The slave side is ready only while the sequencer is idle; the final word
// waits in the output register, so the next frame can be taken meanwhile.
// When the receiver stalls the output word holds and the sequencer waits.
// Reset clears the sequencer, the output valid and the charge-enable bit,
// and sets temp_offset to 40 and current_scale to 1.
module bms_can_frame_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  // Frame input.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // frame_id[28:0], byte0[36:29], byte1[44:37], byte2[52:45], byte3[60:53],
  // byte4[68:61], byte5[76:69], byte6[84:77], byte7[92:85], zeros above.
  input  logic [95:0] s_axis_tdata_i,
  // bus_channel[1:0], extended_id[2].
  input  logic [2:0]  s_axis_tuser_i,
  // Write-record output.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // module_index[3:0], point_index[8:4], value[24:9], zeros above.
  output logic [31:0] m_axis_tdata_o,
  // target[4:0].
  output logic [4:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);
  import bcfd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]  state_q, state_d;
  kind_e       kind_q, kind_d, in_kind;
  logic [2:0]  cnt_q, cnt_d;
  logic [2:0]  step_q, step_d;
  logic [5:0]  rem_q, rem_d;
  logic [3:0]  mod_q, mod_d;
  logic [15:0] acc_q, acc_d;
  logic [63:0] pay_q, pay_d;
  logic        chg_en_q, chg_en_d;
  logic [7:0]  temp_offset_q, current_scale_q;

  logic        out_valid_q, out_valid_d;
  logic [4:0]  out_tgt_q, out_tgt_d;
  logic [3:0]  out_mod_q, out_mod_d;
  logic [4:0]  out_pt_q, out_pt_d;
  logic [15:0] out_val_q, out_val_d;
  logic        out_last_q, out_last_d;

  logic        s_fire, frame_ok, load;
  logic [28:0] in_id;
  logic [6:0]  in_mid;
  logic [7:0]  cur_byte, ws_raw, ws_val;
  logic [15:0] req_cur;
  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;

  // Input decode.
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_id    = s_axis_tdata_i[28:0];
  assign frame_ok = (s_axis_tuser_i[1:0] == ChanDecoded) && s_axis_tuser_i[2];
  // Identifier step above the first cell frame, (id - first) >> 16.
  assign in_mid   = in_id[22:16] - {6'd0, (in_id[15:0] < IdCellLow)};

  always_comb begin
    in_kind = KindNone;
    if (frame_ok) begin
      if (in_id >= IdCellFirst && in_id <= IdTempLast) begin
        in_kind = (in_id >= IdTempFirst) ? KindTemp : KindCell;
      end else if (in_id == IdPackA) begin
        in_kind = KindPackA;
      end else if (in_id == IdPackB) begin
        in_kind = KindPackB;
      end else if (in_id == IdPackC) begin
        in_kind = KindPackC;
      end else if (in_id == IdPackD) begin
        in_kind = KindPackD;
      end
    end
  end

  assign cur_byte = pay_q[{cnt_q, 3'b000} +: 8];
  assign req_cur  = {pay_q[39:32], pay_q[47:40]};
  assign load     = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready_i);

  // Operand selection for the shared adder.
  always_comb begin
    alu_req = '0;
    unique case (state_q)
      S_DIV: begin
        alu_req.a   = {10'd0, rem_q};
        alu_req.b   = CellsPerMod;
        alu_req.sub = 1'b1;
      end
      S_MUL: begin
        alu_req.a = acc_q;
        alu_req.b = current_scale_q[step_q] ? (req_cur << step_q) : 16'd0;
      end
      S_EMIT: begin
        alu_req.sub = 1'b1;
        if (kind_q == KindPackA) begin
          alu_req.a = {12'd0, pay_q[55:52]};
          alu_req.b = WorkStateOfs;
        end else begin
          alu_req.a = {8'd0, cur_byte};
          alu_req.b = {8'd0, temp_offset_q};
        end
      end
      default: alu_req = '0;
    endcase
  end

  bcfd_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Work state wraps modulo 256; charging shows as 4 once enabled.
  assign ws_raw = alu_rsp.sum[7:0];
  assign ws_val = (ws_raw == WorkStateChg && chg_en_q) ? WorkStateChgOn : ws_raw;

  // Sequencer and record builder.
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    cnt_d       = cnt_q;
    step_d      = step_q;
    rem_d       = rem_q;
    mod_d       = mod_q;
    acc_d       = acc_q;
    pay_d       = pay_q;
    chg_en_d    = chg_en_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_tgt_d   = out_tgt_q;
    out_mod_d   = out_mod_q;
    out_pt_d    = out_pt_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_fire && in_kind != KindNone) begin
          kind_d = in_kind;
          pay_d  = s_axis_tdata_i[92:29];
          cnt_d  = 3'd0;
          step_d = 3'd0;
          acc_d  = 16'd0;
          rem_d  = in_mid[5:0];
          mod_d  = (in_kind == KindTemp) ? in_id[19:16] : 4'd0;
          if (in_kind == KindCell) begin
            state_d = S_DIV;
          end else if (in_kind == KindPackD) begin
            state_d  = S_MUL;
            chg_en_d = s_axis_tdata_i[42];
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_DIV: begin
        // mod_q counts the quotient, rem_q keeps the remainder.
        if (alu_rsp.carry) begin
          rem_d = alu_rsp.sum[5:0];
          mod_d = mod_q + 4'd1;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_MUL: begin
        acc_d  = alu_rsp.sum;
        step_d = step_q + 3'd1;
        if (step_q == 3'd7) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load) begin
          out_valid_d = 1'b1;
          out_mod_d   = 4'd0;
          out_pt_d    = 5'd0;
          out_tgt_d   = TgtCellVolt;
          out_val_d   = 16'd0;
          out_last_d  = (cnt_q == last_index(kind_q));
          cnt_d       = cnt_q + 3'd1;
          if (out_last_d) begin
            state_d = S_IDLE;
          end
          unique case (kind_q)
            KindCell: begin
              out_tgt_d = TgtCellVolt;
              out_mod_d = mod_q;
              out_pt_d  = {rem_q[2:0], cnt_q[1:0]};
              unique case (cnt_q[1:0])
                2'd0: out_val_d = {pay_q[15:8], pay_q[7:0]};
                2'd1: out_val_d = {pay_q[31:24], pay_q[23:16]};
                2'd2: out_val_d = {pay_q[47:40], pay_q[39:32]};
                default: out_val_d = {pay_q[63:56], pay_q[55:48]};
              endcase
            end
            KindTemp: begin
              out_tgt_d = TgtModTemp;
              out_mod_d = mod_q;
              out_pt_d  = {2'd0, cnt_q};
              out_val_d = sext8(alu_rsp.sum[7:0]);
            end
            KindPackA: begin
              unique case (cnt_q)
                3'd0: begin
                  out_tgt_d = TgtTotalVolt;
                  out_val_d = {pay_q[7:0], pay_q[15:8]};
                end
                3'd1: begin
                  out_tgt_d = TgtTotalCurr;
                  out_val_d = {pay_q[23:16], pay_q[31:24]};
                end
                3'd2: begin
                  out_tgt_d = TgtSoc;
                  out_val_d = {8'd0, pay_q[39:32]};
                end
                3'd3: begin
                  out_tgt_d = TgtImdState;
                  out_val_d = {8'd0, pay_q[47:40]};
                end
                default: begin
                  out_tgt_d = TgtWorkState;
                  out_val_d = {8'd0, ws_val};
                end
              endcase
            end
            KindPackB: begin
              if (cnt_q == 3'd0) begin
                out_tgt_d = TgtMaxCell;
                out_val_d = {pay_q[7:0], pay_q[15:8]};
              end else begin
                out_tgt_d = TgtMinCell;
                out_val_d = {pay_q[23:16], pay_q[31:24]};
              end
            end
            KindPackC: begin
              out_tgt_d = (cnt_q == 3'd0) ? TgtMaxTemp : TgtMinTemp;
              out_val_d = sext8(alu_rsp.sum[7:0]);
            end
            KindPackD: begin
              unique case (cnt_q)
                3'd0: begin
                  out_tgt_d = TgtAir1;
                  out_val_d = {14'd0, pay_q[3:2]};
                end
                3'd1: begin
                  out_tgt_d = TgtAir2;
                  out_val_d = {14'd0, pay_q[5:4]};
                end
                3'd2: begin
                  out_tgt_d = TgtAir3;
                  out_val_d = {14'd0, pay_q[7:6]};
                end
                3'd3: begin
                  out_tgt_d = TgtChgEnable;
                  out_val_d = {15'd0, chg_en_q};
                end
                3'd4: begin
                  out_tgt_d = TgtChgReqVolt;
                  out_val_d = {pay_q[23:16], pay_q[31:24]};
                end
                3'd5: begin
                  out_tgt_d = TgtChgReqCurr;
                  out_val_d = acc_q;
                end
                default: begin
                  out_tgt_d = TgtChgOutVolt;
                  out_val_d = {pay_q[55:48], pay_q[63:56]};
                end
              endcase
            end
            default: begin
              out_valid_d = 1'b0;
              state_d     = S_IDLE;
            end
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      kind_q          <= KindNone;
      cnt_q           <= 3'd0;
      step_q          <= 3'd0;
      chg_en_q        <= 1'b0;
      out_valid_q     <= 1'b0;
      temp_offset_q   <= TempOffsetRst;
      current_scale_q <= CurrentScaleRst;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
      chg_en_q    <= chg_en_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgTempOffset:   temp_offset_q   <= cfg_wdata_i;
          CfgCurrentScale: current_scale_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    mod_q      <= mod_d;
    acc_q      <= acc_d;
    pay_q      <= pay_d;
    out_tgt_q  <= out_tgt_d;
    out_mod_q  <= out_mod_d;
    out_pt_q   <= out_pt_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_val_q, out_pt_q, out_mod_q};
  assign m_axis_tuser_o  = out_tgt_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTH
  // The quotient of a step below 64 by six never exceeds ten.
  a_div_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (mod_q <= 4'd10))
    else $error("cell module quotient out of range");

  // A decodable frame always starts the sequencer.
  a_frame_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && in_kind != KindNone) |=> (state_q != S_IDLE))
    else $error("accepted frame did not start the sequencer");

  // The charge-enable word reports the stored flag.
  a_chg_en_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == TgtChgEnable)
      |-> (m_axis_tdata_o[9] == chg_en_q))
    else $error("charge-enable word differs from stored flag");

  // Point indexes stay within a module.
  a_point_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[8:4] <= 5'd23))
    else $error("point index out of range");
`endif

endmodule

// ===== rtl/bcfd_alu.sv =====
`timescale 1ns / 1ps
// Shared 16-bit adder/subtractor of the CAN frame decoder.
// Depends on bcfd_pkg for the request and response structs.
module bcfd_alu (
  input  bcfd_pkg::alu_req_t req_i,
  output bcfd_pkg::alu_rsp_t rsp_o
);
  import bcfd_pkg::*;

  logic [15:0] b_op;
  logic [16:0] total;

  assign b_op  = req_i.sub ? ~req_i.b : req_i.b;
  assign total = {1'b0, req_i.a} + {1'b0, b_op} + {16'd0, req_i.sub};

  assign rsp_o.sum   = total[15:0];
  assign rsp_o.carry = total[16];

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the battery-management CAN frame decoder.
// Depends on bcfd_pkg and bms_can_frame_decoder_unit, which needs bcfd_alu.
module tb_top;
  import bcfd_pkg::*;

  // One received CAN frame as it travels on the slave stream.
  typedef struct packed {
    logic [1:0]      chan;
    logic            ext;
    logic [28:0]     id;
    logic [7:0][7:0] pay;  // pay[0] is byte0
  } frame_t;

  // One register-write word as it leaves the master stream.
  typedef struct packed {
    logic [4:0]  target;
    logic [3:0]  module_idx;
    logic [4:0]  point;
    logic [15:0] value;
    logic        last;
  } write_t;

  // Margin after the last owed word, plenty for a frame that gives no words
  // to leave the sequencer.
  localparam int DrainCycles = 32;
  localparam int LongHold    = 400;
  // No correct run stays quiet for much longer than the long receiver hold.
  localparam int QuietLimit  = 3000;
  localparam int PrintLimit  = 50;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = '0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [95:0] s_axis_tdata_i = '0;
  logic [2:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [4:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  bms_can_frame_decoder_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Frames waiting to be offered, and the words the decoder still owes us.
  frame_t frames_to_send[$];
  write_t due_writes[$];
  int     err_count = 0;

  // Our own copy of the decoder's registers and its charge-enable bit.
  logic [7:0] temp_ofs  = TempOffsetRst;
  logic [7:0] cur_scale = CurrentScaleRst;
  logic       chg_en    = 1'b0;

  // Control from the stimulus sequence to the receiver.
  logic long_hold_go = 1'b0;

  task automatic log_mismatch(input string what);
    if (err_count < PrintLimit) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
    // Past the print limit mismatches are only counted.
    err_count++;
  endtask

  function automatic write_t wr_rec(input logic [4:0] tg, input logic [3:0] md,
                                    input logic [4:0] pt, input logic [15:0] val);
    write_t w;
    w.target     = tg;
    w.module_idx = md;
    w.point      = pt;
    w.value      = val;
    w.last       = 1'b0;
    return w;
  endfunction

  // A raw temperature byte less the offset, taken as a signed byte and
  // widened with its sign.
  function automatic logic [15:0] temp_code(input logic [7:0] raw);
    logic [7:0] t;
    t = raw - temp_ofs;
    return {{8{t[7]}}, t};
  endfunction

  // Works out the words one accepted frame gives and queues them. Runs in
  // acceptance order, so the charge-enable bit follows the decoder's own.
  task automatic decode_frame(input frame_t f);
    write_t      recs[$];
    logic [31:0] span;
    logic [15:0] step;
    logic [7:0]  ws;
    logic [23:0] req;
    if (f.chan != ChanDecoded || !f.ext) return;
    if (f.id >= IdCellFirst && f.id <= IdTempLast) begin
      if (f.id >= IdTempFirst) begin
        for (int i = 0; i < TempCount; i++) begin
          recs.push_back(wr_rec(TgtModTemp, f.id[19:16], 5'(i), temp_code(f.pay[i])));
        end
      end else begin
        // The identifier step counts blocks of four cells, six per module.
        span = 32'(f.id) - 32'(IdCellFirst);
        step = span[31:16];
        for (int i = 0; i < 4; i++) begin
          recs.push_back(wr_rec(TgtCellVolt, 4'(step / 6), 5'((step % 6) * 4 + i),
                                {f.pay[2*i+1], f.pay[2*i]}));
        end
      end
    end else begin
      case (f.id)
        IdPackA: begin
          // Work state wraps below 2; state 3 reads as 4 while charging.
          ws = {4'h0, f.pay[6][7:4]} - 8'(WorkStateOfs);
          if (ws == WorkStateChg && chg_en) ws = WorkStateChgOn;
          recs.push_back(wr_rec(TgtTotalVolt, '0, '0, {f.pay[0], f.pay[1]}));
          recs.push_back(wr_rec(TgtTotalCurr, '0, '0, {f.pay[2], f.pay[3]}));
          recs.push_back(wr_rec(TgtSoc, '0, '0, 16'(f.pay[4])));
          recs.push_back(wr_rec(TgtImdState, '0, '0, 16'(f.pay[5])));
          recs.push_back(wr_rec(TgtWorkState, '0, '0, 16'(ws)));
        end
        IdPackB: begin
          recs.push_back(wr_rec(TgtMaxCell, '0, '0, {f.pay[0], f.pay[1]}));
          recs.push_back(wr_rec(TgtMinCell, '0, '0, {f.pay[2], f.pay[3]}));
        end
        IdPackC: begin
          recs.push_back(wr_rec(TgtMaxTemp, '0, '0, temp_code(f.pay[0])));
          recs.push_back(wr_rec(TgtMinTemp, '0, '0, temp_code(f.pay[1])));
        end
        IdPackD: begin
          req    = 24'({f.pay[4], f.pay[5]}) * 24'(cur_scale);
          chg_en = f.pay[1][5];
          recs.push_back(wr_rec(TgtAir1, '0, '0, 16'(f.pay[0][3:2])));
          recs.push_back(wr_rec(TgtAir2, '0, '0, 16'(f.pay[0][5:4])));
          recs.push_back(wr_rec(TgtAir3, '0, '0, 16'(f.pay[0][7:6])));
          recs.push_back(wr_rec(TgtChgEnable, '0, '0, 16'(chg_en)));
          recs.push_back(wr_rec(TgtChgReqVolt, '0, '0, {f.pay[2], f.pay[3]}));
          recs.push_back(wr_rec(TgtChgReqCurr, '0, '0, req[15:0]));
          recs.push_back(wr_rec(TgtChgOutVolt, '0, '0, {f.pay[6], f.pay[7]}));
        end
        default: ;
      endcase
    end
    if (recs.size() != 0) recs[recs.size()-1].last = 1'b1;
    foreach (recs[i]) due_writes.push_back(recs[i]);
  endtask

  function automatic frame_t mk(input logic [1:0] c, input logic e,
                                input logic [28:0] id, input logic [63:0] p);
    frame_t f;
    f.chan = c;
    f.ext  = e;
    f.id   = id;
    f.pay  = p;
    return f;
  endfunction

  // Random frame: mostly well-formed frames of every kind with random
  // payload, some identifiers anywhere in the cell/temperature span, and a
  // share of noise on any channel with any identifier.
  function automatic frame_t rand_frame();
    frame_t f;
    int     sel;
    f   = mk(ChanDecoded, 1'b1, IdPackA, {$urandom, $urandom});
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      f.chan = 2'($urandom_range(0, 3));
      f.ext  = 1'($urandom_range(0, 1));
      f.id   = $urandom_range(0, 1) ? 29'($urandom) : IdPackD;
    end else if (sel < 14) begin
      f.id = IdCellFirst + 29'($urandom % (32'(IdTempLast - IdCellFirst) + 1));
    end else if (sel < 34) begin
      f.id = IdCellFirst + ({9'($urandom_range(0, 63)), 20'h0} >> 4);
    end else if (sel < 50) begin
      f.id = IdTempFirst + {13'($urandom_range(0, 5)), 16'h0};
    end else if (sel < 62) begin
      f.id = IdPackA;
      // Work state 3 is the one the charge-enable bit changes.
      if ($urandom_range(0, 2) == 0) f.pay[6][7:4] = 4'h5;
    end else if (sel < 72) begin
      f.id = IdPackB;
    end else if (sel < 80) begin
      f.id = IdPackC;
    end else begin
      f.id = IdPackD;
    end
    return f;
  endfunction

  // Sender: bursts of random length separated by random gaps, some of
  // them zero so that back-to-back stretches occur.
  frame_t on_bus = '0;
  frame_t next_frame;
  int     burst_left = 0;
  int     gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      burst_left      <= 0;
      gap_left        <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) decode_frame(on_bus);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (gap_left != 0) begin
          gap_left        <= gap_left - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (frames_to_send.size() != 0) begin
          next_frame      = frames_to_send.pop_front();
          on_bus          <= next_frame;
          s_axis_tdata_i  <= {3'b000, next_frame.pay, next_frame.id};
          s_axis_tuser_i  <= {next_frame.ext, next_frame.chan};
          s_axis_tvalid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: a stall pattern that switches between always ready, coin
  // flips, mostly stalled and a fixed 3-of-4 rhythm, plus one long hold-off
  // on request so that the decoder fills up and stalls its input.
  int   rx_mode = 0;
  int   rx_mode_left = 0;
  int   rx_hold_left = 0;
  int   rx_tick = 0;
  logic long_hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      rx_mode_left    <= 0;
      rx_hold_left    <= 0;
    end else begin
      rx_tick <= rx_tick + 1;
      if (long_hold_go && !long_hold_done) begin
        long_hold_done  <= 1'b1;
        rx_hold_left    <= LongHold;
        m_axis_tready_i <= 1'b0;
      end else if (rx_hold_left != 0) begin
        rx_hold_left    <= rx_hold_left - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      <= $urandom_range(0, 3);
          rx_mode_left <= $urandom_range(10, 80);
        end else begin
          rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
          0:       m_axis_tready_i <= 1'b1;
          1:       m_axis_tready_i <= 1'($urandom_range(0, 1));
          2:       m_axis_tready_i <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready_i <= (rx_tick % 4 != 0);
        endcase
      end
    end
  end

  // Monitor: every accepted word is checked against the oldest one owed.
  write_t got;
  write_t want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.target     = m_axis_tuser_o;
      got.module_idx = m_axis_tdata_o[3:0];
      got.point      = m_axis_tdata_o[8:4];
      got.value      = m_axis_tdata_o[24:9];
      got.last       = m_axis_tlast_o;
      if (due_writes.size() == 0) begin
        log_mismatch($sformatf("unexpected word tgt=%0d mod=%0d pt=%0d val=%h last=%b",
                               got.target, got.module_idx, got.point, got.value, got.last));
      end else begin
        want = due_writes.pop_front();
        if (got.target !== want.target || got.module_idx !== want.module_idx ||
            got.point !== want.point || got.value !== want.value ||
            got.last !== want.last) begin
          log_mismatch($sformatf(
              "got tgt=%0d mod=%0d pt=%0d val=%h last=%b, want %0d %0d %0d %h %b",
              got.target, got.module_idx, got.point, got.value, got.last,
              want.target, want.module_idx, want.point, want.value, want.last));
        end
      end
    end
  end

  // Watchdog: too long without a word moving on either side ends the run.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Waits until every frame is taken and every owed word has arrived, then
  // lets a frame that gives no words leave the sequencer.
  task automatic settle();
    while (frames_to_send.size() != 0 || s_axis_tvalid_i || due_writes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [0:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == CfgTempOffset) temp_ofs = val;
    else cur_scale = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames under the reset register values. Frames on the wrong
    // channel, with a standard identifier or with an unknown identifier
    // come first and must give nothing.
    frames_to_send.push_back(mk(2'd0, 1'b1, IdPackA, 64'h0123_4567_89AB_CDEF));
    frames_to_send.push_back(mk(2'd1, 1'b1, IdPackA, 64'h0123_4567_89AB_CDEF));
    frames_to_send.push_back(mk(2'd3, 1'b1, IdPackA, 64'h0123_4567_89AB_CDEF));
    frames_to_send.push_back(mk(ChanDecoded, 1'b0, IdPackA, 64'h0123_4567_89AB_CDEF));
    frames_to_send.push_back(mk(ChanDecoded, 1'b1, 29'h1FFF_FFFF, '1));
    frames_to_send.push_back(mk(ChanDecoded, 1'b1, 29'h0, '0));
    frames_to_send.push_back(mk(ChanDecoded, 1'b1, IdCellFirst - 29'd1, '1));
    frames_to_send.push_back(mk(ChanDecoded, 1'b1, IdTempLast + 29'd1, '1));
    // Cell frames: first and last module step, an identifier off the step
    // and the one just below the temperature range.
    frames_to_send.push_back(mk(ChanDecoded, 1'b1, IdCellFirst, 64'hFFFF_0000_8000_7FFF));
    frames_to_send.push_back(mk(ChanDecoded, 1'b1, 29'h183F50F3, 64'h0123_4567_89AB_CDEF));
    frames_to_send.push_back(mk(ChanDecoded, 1'b1, IdCellFirst + 29'h12345,
                                64'hFEDC_BA98_7654_3210));
    frames_to_send.push_back(mk(ChanDecoded, 1'b1, IdTempFirst - 29'd1, '1));
    // Temperature frames around the offset and at the byte extremes.
    frames_to_send.push_back(mk(ChanDecoded, 1'b1, IdTempFirst, 64'hFF80_7F29_2827_0100));
    frames_to_send.push_back(mk(ChanDecoded, 1'b1, IdTempLast, 64'h00FF_A8A7_0028_FF00));
    frames_to_send.push_back(mk(ChanDecoded, 1'b1, IdTempLast - 29'd1, 64'h1357_9BDF_2468_ACE0));
    // Pack frames: work state below 2 wraps, and state 3 with the
    // charge-enable bit clear, set by the charger frame, and clear again.
    frames_to_send.push_back(mk(ChanDecoded, 1'b1, IdPackA, 64'hAA0F_FF00_8001_FFFF));
    frames_to_send.push_back(mk(ChanDecoded, 1'b1, IdPackA, 64'h551F_00FF_7FFE_0000));
    frames_to_send.push_back(mk(ChanDecoded, 1'b1, IdPackA, 64'h0050_1234_5678_9ABC));
    frames_to_send.push_back(mk(ChanDecoded, 1'b1, IdPackD, 64'hFFFF_FFFF_FFFF_20FC));
    frames_to_send.push_back(mk(ChanDecoded, 1'b1, IdPackA, 64'h0050_1234_5678_9ABC));
    frames_to_send.push_back(mk(ChanDecoded, 1'b1, IdPackA, 64'hFFFF_FFFF_FFFF_FFFF));
    frames_to_send.push_back(mk(ChanDecoded, 1'b1, IdPackB, 64'h0000_0000_FFFF_0000));
    frames_to_send.push_back(mk(ChanDecoded, 1'b1, IdPackC, 64'h0000_0000_0000_FF00));
    frames_to_send.push_back(mk(ChanDecoded, 1'b1, IdPackD, 64'h1234_0000_5678_DF03));
    frames_to_send.push_back(mk(ChanDecoded, 1'b1, IdPackA, 64'h0050_1234_5678_9ABC));

    // Random phases, each under its own register setting and started only
    // once the previous one has fully drained.
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          set_reg(CfgTempOffset, 8'd0);
          set_reg(CfgCurrentScale, 8'd0);
        end
        1: begin
          set_reg(CfgTempOffset, 8'd255);
          set_reg(CfgCurrentScale, 8'd255);
        end
        2: begin
          set_reg(CfgTempOffset, 8'($urandom_range(0, 255)));
          set_reg(CfgCurrentScale, 8'($urandom_range(0, 255)));
        end
        default: begin
          set_reg(CfgTempOffset, 8'd128);
          set_reg(CfgCurrentScale, 8'd2);
        end
      endcase
      for (int n = 0; n < 56; n++) frames_to_send.push_back(rand_frame());
      // In the first phase the receiver holds off for a long stretch while
      // the sender keeps offering frames.
      if (ph == 0) long_hold_go <= 1'b1;
    end

    settle();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
